### design/chunked_body_decoder_assert.svh
// Assertion macros shared by the chunked body decoder modules.
`ifndef CHUNKED_BODY_DECODER_ASSERT_SVH
`define CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked body decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked body decoder: next-cycle check failed");

`else

`define CBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/cbd_pkg.sv
// Types, constants and helper functions for the chunked body decoder.
package cbd_pkg;

    // Width of the chunk byte counter
    localparam int COUNT_BITS = 60;

    localparam logic [3:0] MAX_SIZE_CHARS_RESET = 4'd15;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Bytes dropped after each chunk payload
    localparam logic [1:0] TRAILER_SKIP = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_LF = 3'd1,
        PH_DATA    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERRCHAR = 3'd5,
        PH_ERRLONG = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_END     = 3'd2,
        KIND_BADCHAR = 3'd3,
        KIND_TOOLONG = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    // Decode one hexadecimal digit character
    function automatic digit_t hex_value(input logic [7:0] b);
        digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.val = 4'(b - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

### design/cbd_out_reg.sv
// Result register that holds one decoded request until the sink takes it.
module cbd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cbd_pkg::result_t result,
    input  logic             out_stall,
    output logic             ready,
    output logic             out_valid,
    output logic [2:0]       out_kind,
    output logic [7:0]       out_byte
);

    logic             valid_reg;
    logic             valid_next;
    cbd_pkg::result_t data_reg;

    // Free when empty or when the held request leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (!out_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on load
    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = data_reg.kind;
    assign out_byte  = data_reg.data;

endmodule

### design/cbd_parser.sv
// Framing state machine: classifies each body byte and tracks chunk size.
`include "chunked_body_decoder_assert.svh"

module cbd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [3:0]       cfg_wr_data,
    input  logic             fire,
    input  logic [7:0]       data,
    output cbd_pkg::result_t result
);

    logic [3:0]                     max_size_chars_reg;
    cbd_pkg::phase_t                phase_reg;
    cbd_pkg::phase_t                phase_next;
    logic [cbd_pkg::COUNT_BITS-1:0] remaining_reg;
    logic [cbd_pkg::COUNT_BITS-1:0] remaining_next;
    logic [3:0]                     size_chars_seen_reg;
    logic [3:0]                     size_chars_seen_next;
    logic [1:0]                     skip_left_reg;
    logic [1:0]                     skip_left_next;
    cbd_pkg::digit_t                digit;

    assign digit = cbd_pkg::hex_value(data);

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_size_chars_reg <= cbd_pkg::MAX_SIZE_CHARS_RESET;
        end else if (cfg_wr_en) begin
            max_size_chars_reg <= cfg_wr_data;
        end
    end

    // Classify the byte and work out the next state
    always_comb
    begin
        phase_next           = phase_reg;
        remaining_next       = remaining_reg;
        size_chars_seen_next = size_chars_seen_reg;
        skip_left_next       = skip_left_reg;
        result.kind          = cbd_pkg::KIND_FRAME;
        result.data          = 8'd0;
        case (phase_reg)
            cbd_pkg::PH_SIZE:
            begin
                if (data == cbd_pkg::CHAR_CR) begin
                    phase_next = cbd_pkg::PH_SIZE_LF;
                end else if (size_chars_seen_reg >= max_size_chars_reg) begin
                    phase_next  = cbd_pkg::PH_ERRLONG;
                    result.kind = cbd_pkg::KIND_TOOLONG;
                end else if (!digit.ok) begin
                    phase_next  = cbd_pkg::PH_ERRCHAR;
                    result.kind = cbd_pkg::KIND_BADCHAR;
                end else begin
                    remaining_next = {remaining_reg[cbd_pkg::COUNT_BITS-5:0], digit.val};
                    size_chars_seen_next = size_chars_seen_reg + 4'd1;
                end
            end
            cbd_pkg::PH_SIZE_LF:
            begin
                if (data != cbd_pkg::CHAR_LF || size_chars_seen_reg == 4'd0) begin
                    phase_next  = cbd_pkg::PH_ERRCHAR;
                    result.kind = cbd_pkg::KIND_BADCHAR;
                end else if (remaining_reg == '0) begin
                    phase_next  = cbd_pkg::PH_DONE;
                    result.kind = cbd_pkg::KIND_END;
                end else begin
                    phase_next = cbd_pkg::PH_DATA;
                end
            end
            cbd_pkg::PH_DATA:
            begin
                result.kind    = cbd_pkg::KIND_PAYLOAD;
                result.data    = data;
                remaining_next = remaining_reg - cbd_pkg::COUNT_BITS'(1);
                if (remaining_reg == cbd_pkg::COUNT_BITS'(1)) begin
                    phase_next     = cbd_pkg::PH_SKIP;
                    skip_left_next = cbd_pkg::TRAILER_SKIP;
                end
            end
            cbd_pkg::PH_SKIP:
            begin
                skip_left_next = skip_left_reg - 2'd1;
                if (skip_left_reg == 2'd1) begin
                    phase_next           = cbd_pkg::PH_SIZE;
                    size_chars_seen_next = 4'd0;
                    remaining_next       = '0;
                end
            end
            cbd_pkg::PH_DONE:
            begin
                result.kind = cbd_pkg::KIND_END;
            end
            cbd_pkg::PH_ERRCHAR:
            begin
                result.kind = cbd_pkg::KIND_BADCHAR;
            end
            default:
            begin
                phase_next  = cbd_pkg::PH_ERRLONG;
                result.kind = cbd_pkg::KIND_TOOLONG;
            end
        endcase
    end

    // Advance state once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg           <= cbd_pkg::PH_SIZE;
            remaining_reg       <= '0;
            size_chars_seen_reg <= 4'd0;
            skip_left_reg       <= 2'd0;
        end else if (fire) begin
            phase_reg           <= phase_next;
            remaining_reg       <= remaining_next;
            size_chars_seen_reg <= size_chars_seen_next;
            skip_left_reg       <= skip_left_next;
        end
    end

    // Skip count lives only in the trailer phase
    `CBD_ASSERT_IMP(a_skip_only_in_skip, clk, rst_n, skip_left_reg != 2'd0, phase_reg == cbd_pkg::PH_SKIP)
    // End of body is terminal
    `CBD_ASSERT_NXT(a_done_sticky, clk, rst_n, phase_reg == cbd_pkg::PH_DONE, phase_reg == cbd_pkg::PH_DONE)
    // Bad-character error is terminal
    `CBD_ASSERT_NXT(a_errchar_sticky, clk, rst_n, phase_reg == cbd_pkg::PH_ERRCHAR, phase_reg == cbd_pkg::PH_ERRCHAR)

endmodule

### design/chunked_body_decoder.sv
// Top level: input register, framing parser and result register.
// An accepted request waits in the input register until the result register has room; its parsed result is held there.
// Throughput: one byte per cycle while out_stall is low; the parser updates its 60-bit count once per consumed byte.
// in_stall rises only when the input register is full and the result register cannot drain.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the parser
// to reading a size line with a zero count, and sets the size-line limit to 15.
`include "chunked_body_decoder_assert.svh"

module chunked_body_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             in_fire;
    logic             s1_fire;
    logic             out_ready;
    cbd_pkg::result_t result;

    // Hand the held byte to the parser when the result register has room
    assign s1_fire  = s1_valid_reg && out_ready;
    assign in_stall = s1_valid_reg && !out_ready;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the input byte
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_byte_reg <= in_byte;
        end
    end

    cbd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (s1_fire),
        .data        (s1_byte_reg),
        .result      (result)
    );

    cbd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire),
        .result    (result),
        .out_stall (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_kind  (out_kind),
        .out_byte  (out_byte)
    );

    // An accepted request is held for the parser
    `CBD_ASSERT_NXT(a_accept_held, clk, rst_n, in_fire, s1_valid_reg)
    // A parsed request always lands in the result register
    `CBD_ASSERT_NXT(a_parse_lands, clk, rst_n, s1_fire, out_valid)
    // Only payload results carry a byte
    `CBD_ASSERT_IMP(a_byte_zero, clk, rst_n, out_valid && (out_kind != cbd_pkg::KIND_PAYLOAD), out_byte == 8'd0)

endmodule
